/* hdl/rib_pkg.sv */
// ----------------------------------------------------------------------------
// rib_pkg
// Shared types and constants for the inverse-mapped bilinear rotation block.
// ----------------------------------------------------------------------------
package rib_pkg;

  localparam int unsigned DimBits  = 8;
  localparam int unsigned FracBits = 14;
  localparam int unsigned PosBits  = FracBits + 15;

  typedef logic signed [PosBits-1:0] pos_t;

  typedef enum logic [2:0] {
    REG_COS = 3'd0,
    REG_SIN = 3'd1,
    REG_CX  = 3'd2,
    REG_CY  = 3'd3,
    REG_COLS = 3'd4,
    REG_ROWS = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [DimBits-1:0] x0;
    logic [DimBits-1:0] y0;
    logic [7:0]         fx;
    logic [7:0]         fy;
    logic               in_frame;
  } samp_t;

endpackage

/* hdl/rib_front.sv */
// ----------------------------------------------------------------------------
// rib_front
// Maps an output pixel back through the rotation and classifies it.
// Two register stages: products, then sum and bounds check.
// ----------------------------------------------------------------------------
module rib_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [7:0]         row_i,
  input  logic [7:0]         col_i,
  input  logic signed [15:0] cos_i,
  input  logic signed [15:0] sin_i,
  input  logic [8:0]         cx_i,
  input  logic [8:0]         cy_i,
  input  logic [8:0]         cols_i,
  input  logic [8:0]         rows_i,
  output logic               valid_o,
  output rib_pkg::samp_t     samp_o
);

  logic signed [9:0]  dx, dy;
  logic signed [26:0] pxc_q, pys_q, pxs_q, pyc_q;
  rib_pkg::pos_t      cxs_q, cys_q;
  logic               v1_q, v2_q;
  rib_pkg::pos_t      sx, sy;
  rib_pkg::pos_t      xlim, ylim;
  logic [8:0]         cl, rl;
  rib_pkg::samp_t     samp_q;

  assign dx = $signed({1'b0, col_i, 1'b0}) - $signed({1'b0, cx_i});
  assign dy = $signed({1'b0, row_i, 1'b0}) - $signed({1'b0, cy_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxc_q <= 27'(dx * cos_i);
      pys_q <= 27'(dy * sin_i);
      pxs_q <= 27'(dx * sin_i);
      pyc_q <= 27'(dy * cos_i);
      cxs_q <= rib_pkg::pos_t'(cx_i) <<< rib_pkg::FracBits;
      cys_q <= rib_pkg::pos_t'(cy_i) <<< rib_pkg::FracBits;
    end
  end

  assign cl = (cols_i < 9'd2) ? 9'd2 : (cols_i > 9'd256) ? 9'd256 : cols_i;
  assign rl = (rows_i < 9'd2) ? 9'd2 : (rows_i > 9'd256) ? 9'd256 : rows_i;
  assign xlim = rib_pkg::pos_t'(9'(cl - 9'd1)) <<< (rib_pkg::FracBits + 1);
  assign ylim = rib_pkg::pos_t'(9'(rl - 9'd1)) <<< (rib_pkg::FracBits + 1);
  assign sx = rib_pkg::pos_t'(pxc_q) + rib_pkg::pos_t'(pys_q) + cxs_q;
  assign sy = rib_pkg::pos_t'(pyc_q) - rib_pkg::pos_t'(pxs_q) + cys_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      samp_q.in_frame <= (sx > 0) && (sy > 0) && (sx < xlim) && (sy < ylim);
      samp_q.x0 <= sx[rib_pkg::FracBits+8 -: 8];
      samp_q.y0 <= sy[rib_pkg::FracBits+8 -: 8];
      samp_q.fx <= sx[rib_pkg::FracBits -: 8];
      samp_q.fy <= sy[rib_pkg::FracBits -: 8];
    end
  end

  assign valid_o = v2_q;
  assign samp_o  = samp_q;

endmodule

/* hdl/rib_back.sv */
// ----------------------------------------------------------------------------
// rib_back
// Frame store in four parity banks, neighbor fetch and bilinear blend.
// ----------------------------------------------------------------------------
module rib_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           wr_i,
  input  logic [7:0]     wrow_i,
  input  logic [7:0]     wcol_i,
  input  logic [23:0]    wdata_i,
  input  logic           valid_i,
  input  rib_pkg::samp_t samp_i,
  output logic           valid_o,
  output logic [23:0]    pix_o,
  output logic           inside_o
);

  logic [23:0] bank0 [16384];
  logic [23:0] bank1 [16384];
  logic [23:0] bank2 [16384];
  logic [23:0] bank3 [16384];
  logic [23:0] rd_q [4];
  logic [6:0]  xe, xo, ye, yo;
  logic [7:0]  x1, y1;
  logic        v1_q, v2_q, v3_q;
  rib_pkg::samp_t s1_q;
  logic [8:0]  gx, gy;
  logic [23:0] p00, p01, p10, p11;
  logic [17:0] wt_q [4];
  logic [23:0] c_q [4];
  logic        in2_q, in3_q;
  logic [23:0] pix_q;
  logic        wr_q;
  logic [7:0]  wrow_q, wcol_q;
  logic [23:0] wdata_q;

  assign x1 = samp_i.x0 + 8'd1;
  assign y1 = samp_i.y0 + 8'd1;
  assign xe = samp_i.x0[0] ? x1[7:1] : samp_i.x0[7:1];
  assign xo = samp_i.x0[7:1];
  assign ye = samp_i.y0[0] ? y1[7:1] : samp_i.y0[7:1];
  assign yo = samp_i.y0[7:1];

  // writes pass a register stage before they land so that earlier lookups still read old data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
    end else if (en_i) begin
      wr_q <= wr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_q && en_i) begin
      unique case ({wrow_q[0], wcol_q[0]})
        2'b00: bank0[{wrow_q[7:1], wcol_q[7:1]}] <= wdata_q;
        2'b01: bank1[{wrow_q[7:1], wcol_q[7:1]}] <= wdata_q;
        2'b10: bank2[{wrow_q[7:1], wcol_q[7:1]}] <= wdata_q;
        default: bank3[{wrow_q[7:1], wcol_q[7:1]}] <= wdata_q;
      endcase
    end
    if (en_i) begin
      wrow_q  <= wrow_i;
      wcol_q  <= wcol_i;
      wdata_q <= wdata_i;
      rd_q[0] <= bank0[{ye, xe}];
      rd_q[1] <= bank1[{ye, xo}];
      rd_q[2] <= bank2[{yo, xe}];
      rd_q[3] <= bank3[{yo, xo}];
      s1_q    <= samp_i;
    end
  end

  always_comb begin
    logic [23:0] ev0, od0, ev1, od1;
    ev0 = s1_q.y0[0] ? rd_q[2] : rd_q[0];
    od0 = s1_q.y0[0] ? rd_q[3] : rd_q[1];
    ev1 = s1_q.y0[0] ? rd_q[0] : rd_q[2];
    od1 = s1_q.y0[0] ? rd_q[1] : rd_q[3];
    p00 = s1_q.x0[0] ? od0 : ev0;
    p01 = s1_q.x0[0] ? ev0 : od0;
    p10 = s1_q.x0[0] ? od1 : ev1;
    p11 = s1_q.x0[0] ? ev1 : od1;
  end

  assign gx = 9'd256 - {1'b0, s1_q.fx};
  assign gy = 9'd256 - {1'b0, s1_q.fy};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wt_q[0] <= 18'(gx * gy);
      wt_q[1] <= 18'({1'b0, s1_q.fx} * gy);
      wt_q[2] <= 18'(gx * {1'b0, s1_q.fy});
      wt_q[3] <= 18'(s1_q.fx * s1_q.fy);
      c_q[0]  <= p00;
      c_q[1]  <= p01;
      c_q[2]  <= p10;
      c_q[3]  <= p11;
      in2_q   <= s1_q.in_frame;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        logic [27:0] acc;
        acc = 28'(wt_q[0] * c_q[0][8*k +: 8]) + 28'(wt_q[1] * c_q[1][8*k +: 8])
            + 28'(wt_q[2] * c_q[2][8*k +: 8]) + 28'(wt_q[3] * c_q[3][8*k +: 8])
            + 28'd32768;
        pix_q[8*k +: 8] <= !in2_q ? 8'd0 : (|acc[27:24]) ? 8'hFF : acc[23:16];
      end
      in3_q <= in2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o  = v3_q;
  assign pix_o    = pix_q;
  assign inside_o = in3_q;

endmodule

/* hdl/rib_queue.sv */
// ----------------------------------------------------------------------------
// rib_queue
// Result queue; holds finished beats while the sink stalls.
// ----------------------------------------------------------------------------
module rib_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [24:0] data_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [24:0] data_o,
  output logic [3:0]  count_o
);

  logic [24:0] mem_q [8];
  logic [2:0]  wp_q, rp_q;
  logic [3:0]  cnt_q;
  logic        pop;

  assign pop = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 3'd1;
      if (pop) rp_q <= rp_q + 3'd1;
      cnt_q <= cnt_q + 4'(push_i) - 4'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  assign valid_o = cnt_q != 4'd0;
  assign data_o  = mem_q[rp_q];
  assign count_o = cnt_q;

endmodule

/* hdl/rotate_inverse_bilinear_top.sv */
// ----------------------------------------------------------------------------
// rotate_inverse_bilinear_top
// A compute beat passes the mapping registers, the bank read register, the blend
// registers and the queue. Throughput: one beat per cycle unless the pipeline stalls;
// banks by row/column parity give 4 reads a cycle. Writes pass a register before they
// land in the store and give no result. The whole pipeline stalls while two results
// wait in the queue. Reset sets control and config registers, not the frame store.
// ----------------------------------------------------------------------------
module rotate_inverse_bilinear_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        func_i,
  input  logic [7:0]  row_i,
  input  logic [7:0]  col_i,
  input  logic [7:0]  in_red_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_blue_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        inside_res_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic signed [15:0] cos_q, sin_q;
  logic [8:0] cx_q, cy_q, cols_q, rows_q;
  logic       acc, en, fv, bv, bin;
  logic [23:0] bpix;
  rib_pkg::samp_t samp;
  logic [24:0] qd;
  logic [3:0]  qcnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q  <= 16'sd16384;
      sin_q  <= '0;
      cx_q   <= 9'd255;
      cy_q   <= 9'd255;
      cols_q <= 9'd256;
      rows_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rib_pkg::REG_COS:  cos_q  <= cfg_data_i;
        rib_pkg::REG_SIN:  sin_q  <= cfg_data_i;
        rib_pkg::REG_CX:   cx_q   <= cfg_data_i[8:0];
        rib_pkg::REG_CY:   cy_q   <= cfg_data_i[8:0];
        rib_pkg::REG_COLS: cols_q <= cfg_data_i[8:0];
        rib_pkg::REG_ROWS: rows_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // stall once two results wait
  assign en      = qcnt <= 4'd1;
  assign ready_o = en;
  assign acc     = valid_i && ready_o;

  rib_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(acc && func_i),
    .row_i, .col_i, .cos_i(cos_q), .sin_i(sin_q), .cx_i(cx_q), .cy_i(cy_q),
    .cols_i(cols_q), .rows_i(rows_q), .valid_o(fv), .samp_o(samp)
  );

  rib_back u_back (
    .clk_i, .rst_ni, .en_i(en), .wr_i(acc && !func_i), .wrow_i(row_i), .wcol_i(col_i),
    .wdata_i({in_red_i, in_green_i, in_blue_i}), .valid_i(fv), .samp_i(samp),
    .valid_o(bv), .pix_o(bpix), .inside_o(bin)
  );

  rib_queue u_queue (
    .clk_i, .rst_ni, .push_i(bv && en), .data_i({bin, bpix}),
    .valid_o, .ready_i, .data_o(qd), .count_o(qcnt)
  );

  assign inside_res_o = qd[24];
  assign out_red_o    = qd[23:16];
  assign out_green_o  = qd[15:8];
  assign out_blue_o   = qd[7:0];

  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni) qcnt <= 4'd8)
    else $error("result queue overflow");
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid_o && !inside_res_o |-> out_red_o == 8'd0 && out_green_o == 8'd0 && out_blue_o == 8'd0)
    else $error("outside result not black");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni) !en |-> !ready_o)
    else $error("ready while stalled");

endmodule

/* tb/sv/tb_rotate_inverse_bilinear_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotate_inverse_bilinear_top
// Streams pixel writes and rotated-pixel lookups under several rotation,
// centre and size settings; any neighbor a lookup needs is written first.
// A bilinear predictor kept beside the block checks every output beat in order.
// ----------------------------------------------------------------------------
module tb_rotate_inverse_bilinear_top;

  localparam logic [2:0] SpareIdx = 3'd6;
  localparam logic       FnWrite  = 1'b0;
  localparam logic       FnLookup = 1'b1;

  typedef struct {
    logic       func;
    logic [7:0] row, col, r, g, b;
  } pix_req_t;

  typedef struct {
    logic [7:0] r, g, b;
    logic       in_frame;
  } pix_res_t;

  logic        clk_i = 1'b0, rst_ni = 1'b0;
  logic        valid_i = 1'b0, ready_i = 1'b0;
  logic        func_i = 1'b0;
  logic [7:0]  row_i = '0, col_i = '0, in_red_i = '0, in_green_i = '0, in_blue_i = '0;
  logic        ready_o, valid_o, inside_res_o;
  logic [7:0]  out_red_o, out_green_o, out_blue_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  rotate_inverse_bilinear_top DUT (.*);

  pix_req_t    pend_q[$];
  pix_res_t    pix_q[$];
  logic [23:0] frame_m[65536];
  bit          wrote_m[65536];
  int          cos_m, sin_m, cxh_m, cyh_m, cols_m, rows_m;
  int          snd_idle = 17, rcv_idle = 78;
  int          errors = 0;
  bit          took = 1'b0;

  initial forever #6 clk_i = ~clk_i;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic pix_res_t rotate_lookup(input logic [7:0] row, input logic [7:0] col);
    pix_res_t   res;
    longint     dxh, dyh, sxf, syf, xlim, ylim, fx, fy, gx, gy, x0, y0, v;
    int         cc, rr;
    logic [23:0] p00, p01, p10, p11;
    cc = cols_m < 2 ? 2 : (cols_m > 256 ? 256 : cols_m);
    rr = rows_m < 2 ? 2 : (rows_m > 256 ? 256 : rows_m);
    dxh = 2 * longint'(col) - cxh_m;
    dyh = 2 * longint'(row) - cyh_m;
    sxf = dxh * cos_m + dyh * sin_m + (longint'(cxh_m) <<< rib_pkg::FracBits);
    syf = -dxh * sin_m + dyh * cos_m + (longint'(cyh_m) <<< rib_pkg::FracBits);
    xlim = longint'(cc - 1) <<< (rib_pkg::FracBits + 1);
    ylim = longint'(rr - 1) <<< (rib_pkg::FracBits + 1);
    res = '{8'd0, 8'd0, 8'd0, 1'b0};
    if (sxf <= 0 || syf <= 0 || sxf >= xlim || syf >= ylim) return res;
    x0 = sxf >>> (rib_pkg::FracBits + 1);
    y0 = syf >>> (rib_pkg::FracBits + 1);
    fx = (sxf >>> (rib_pkg::FracBits - 7)) & 255;
    fy = (syf >>> (rib_pkg::FracBits - 7)) & 255;
    gx = 256 - fx;
    gy = 256 - fy;
    p00 = frame_m[y0 * 256 + x0];
    p01 = frame_m[y0 * 256 + x0 + 1];
    p10 = frame_m[(y0 + 1) * 256 + x0];
    p11 = frame_m[(y0 + 1) * 256 + x0 + 1];
    for (int sh = 16; sh >= 0; sh -= 8) begin
      v = gx * gy * ((p00 >> sh) & 255) + fx * gy * ((p01 >> sh) & 255)
        + gx * fy * ((p10 >> sh) & 255) + fx * fy * ((p11 >> sh) & 255);
      v = (v + 32768) >>> 16;
      if (v > 255) v = 255;
      if (sh == 16) res.r = v[7:0];
      else if (sh == 8) res.g = v[7:0];
      else res.b = v[7:0];
    end
    res.in_frame = 1'b1;
    return res;
  endfunction

  // top-left neighbor of the source position; returns 1 when it lies inside
  function automatic bit src_corner(input int row, input int col,
                                    output int x0, output int y0);
    longint dxh, dyh, sxf, syf, xlim, ylim;
    int     cc, rr;
    cc = cols_m < 2 ? 2 : (cols_m > 256 ? 256 : cols_m);
    rr = rows_m < 2 ? 2 : (rows_m > 256 ? 256 : rows_m);
    dxh = 2 * longint'(col) - cxh_m;
    dyh = 2 * longint'(row) - cyh_m;
    sxf = dxh * cos_m + dyh * sin_m + (longint'(cxh_m) <<< rib_pkg::FracBits);
    syf = -dxh * sin_m + dyh * cos_m + (longint'(cyh_m) <<< rib_pkg::FracBits);
    xlim = longint'(cc - 1) <<< (rib_pkg::FracBits + 1);
    ylim = longint'(rr - 1) <<< (rib_pkg::FracBits + 1);
    x0 = int'(sxf >>> (rib_pkg::FracBits + 1));
    y0 = int'(syf >>> (rib_pkg::FracBits + 1));
    return !(sxf <= 0 || syf <= 0 || sxf >= xlim || syf >= ylim);
  endfunction

  // input beat: update the frame copy or queue the predicted pixel
  always @(posedge clk_i) begin
    took = valid_i && ready_o;
    if (took) begin
      if (func_i == FnWrite) frame_m[{row_i, col_i}] = {in_red_i, in_green_i, in_blue_i};
      else pix_q.push_back(rotate_lookup(row_i, col_i));
    end
  end

  // output beat
  always @(posedge clk_i) begin
    pix_res_t want;
    if (rst_ni && valid_o && ready_i) begin
      if (pix_q.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        want = pix_q.pop_front();
        if (out_red_o !== want.r) report("red", out_red_o, want.r);
        if (out_green_o !== want.g) report("green", out_green_o, want.g);
        if (out_blue_o !== want.b) report("blue", out_blue_o, want.b);
        if (inside_res_o !== want.in_frame) report("inside", inside_res_o, want.in_frame);
      end
    end
  end

  always @(negedge clk_i) begin
    pix_req_t it;
    if (rst_ni) begin
      if (!valid_i || took) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
          it = pend_q.pop_front();
          func_i <= it.func;
          row_i <= it.row;
          col_i <= it.col;
          in_red_i <= it.r;
          in_green_i <= it.g;
          in_blue_i <= it.b;
          valid_i <= 1'b1;
        end else begin
          valid_i <= 1'b0;
        end
      end
      ready_i <= ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic push_px(input logic func, input int row, input int col);
    pix_req_t it;
    int       x0, y0;
    if (func == FnLookup && src_corner(row, col, x0, y0)) begin
      for (int k = 0; k < 4; k++) begin
        if (!wrote_m[(y0 + k / 2) * 256 + x0 + k % 2])
          push_px(FnWrite, y0 + k / 2, x0 + k % 2);
      end
    end
    it.func = func;
    it.row = 8'(row);
    it.col = 8'(col);
    it.r = 8'($urandom);
    it.g = 8'($urandom);
    it.b = 8'($urandom);
    pend_q.push_back(it);
    if (func == FnWrite) wrote_m[{it.row, it.col}] = 1'b1;
  endtask

  task automatic drain();
    while (pend_q.size() > 0 || valid_i || pix_q.size() > 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input int val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[15:0];
    case (idx)
      rib_pkg::REG_COS:  cos_m = $signed(val[15:0]);
      rib_pkg::REG_SIN:  sin_m = $signed(val[15:0]);
      rib_pkg::REG_CX:   cxh_m = val[8:0];
      rib_pkg::REG_CY:   cyh_m = val[8:0];
      rib_pkg::REG_COLS: cols_m = val[8:0];
      rib_pkg::REG_ROWS: rows_m = val[8:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic setup(input int c, input int s, input int cx, input int cy,
                       input int nc, input int nr);
    drain();
    cfg_write(rib_pkg::REG_COS, c);
    cfg_write(rib_pkg::REG_SIN, s);
    cfg_write(rib_pkg::REG_CX, cx);
    cfg_write(rib_pkg::REG_CY, cy);
    cfg_write(rib_pkg::REG_COLS, nc);
    cfg_write(rib_pkg::REG_ROWS, nr);
    cfg_write(SpareIdx, $urandom);
  endtask

  initial begin
    real th;
    int  pick;
    cos_m = 16384; sin_m = 0; cxh_m = 255; cyh_m = 255; cols_m = 256; rows_m = 256;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // identity: border rows and columns are outside, interior maps onto itself
    push_px(FnLookup, 0, 0);
    push_px(FnLookup, 255, 255);
    push_px(FnLookup, 0, 255);
    push_px(FnLookup, 255, 0);
    push_px(FnLookup, 127, 127);
    push_px(FnLookup, 128, 1);
    push_px(FnLookup, 254, 254);
    setup(-16384, 0, 510, 510, 256, 256);
    push_px(FnLookup, 0, 0);
    push_px(FnLookup, 255, 255);
    push_px(FnLookup, 100, 37);
    setup(0, 16384, 0, 0, 2, 2);
    push_px(FnLookup, 0, 0);
    push_px(FnLookup, 1, 0);
    push_px(FnLookup, 255, 255);
    setup(0, -16384, 300, 200, 0, 511);
    push_px(FnLookup, 10, 200);
    push_px(FnLookup, 200, 10);
    setup(16384, 0, 255, 255, 1, 300);
    push_px(FnLookup, 100, 100);
    push_px(FnLookup, 0, 128);
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 17 : (ph == 1) ? 78 : 0;
      rcv_idle = (ph == 0) ? 78 : (ph == 1) ? 17 : 0;
      for (int k = 0; k < 4; k++) begin
        pick = $urandom_range(3);
        th = $urandom_range(35999) * 3.14159265358979 / 18000.0;
        if (pick == 0)
          setup($urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                $urandom_range(510), $urandom_range(510),
                $urandom_range(511), $urandom_range(511));
        else
          setup($rtoi($cos(th) * 16384.0), $rtoi($sin(th) * 16384.0),
                $urandom_range(510), $urandom_range(510),
                (pick == 1) ? $urandom_range(2, 256) : 256,
                (pick == 1) ? $urandom_range(2, 256) : 256);
        for (int n = 0; n < 50; n++)
          push_px(($urandom_range(9) < 7) ? FnLookup : FnWrite,
                  $urandom_range(255), $urandom_range(255));
      end
    end
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end

endmodule
